@@ rtl/core/mtep_pkg.sv @@
`default_nettype none

package mtep_pkg;

    localparam logic [3:0] KIND_NOTE_OFF  = 4'd0;
    localparam logic [3:0] KIND_NOTE_ON   = 4'd1;
    localparam logic [3:0] KIND_CTRL      = 4'd2;
    localparam logic [3:0] KIND_PROGRAM   = 4'd3;
    localparam logic [3:0] KIND_TEMPO     = 4'd4;
    localparam logic [3:0] KIND_END_TRACK = 4'd5;
    localparam logic [3:0] KIND_META      = 4'd6;
    localparam logic [3:0] KIND_SYSEX     = 4'd7;
    localparam logic [3:0] KIND_UNKNOWN   = 4'd8;

    localparam logic [7:0] STATUS_META   = 8'hFF;
    localparam logic [7:0] STATUS_SYSTEM = 8'hF0;
    localparam logic [7:0] META_TEMPO    = 8'h51;
    localparam logic [7:0] META_END      = 8'h2F;
    localparam logic [3:0] CLS_NOTE_OFF  = 4'h8;
    localparam logic [3:0] CLS_NOTE_ON   = 4'h9;
    localparam logic [3:0] CLS_CTRL      = 4'hB;
    localparam logic [3:0] CLS_PROGRAM   = 4'hC;
    localparam logic [3:0] CLS_PRESSURE  = 4'hD;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [7:0]  event_status;
        logic [3:0]  channel;
        logic [31:0] delta_ticks;
        logic [7:0]  first_value;
        logic [7:0]  second_value;
        logic [7:0]  meta_byte;
        logic [31:0] payload_length;
        logic [23:0] tempo_us;
    } mtep_rec_t;

    function automatic mtep_rec_t mtep_chan_rec(input logic [3:0] kind,
                                                input logic [7:0] status,
                                                input logic [31:0] delta,
                                                input logic [7:0] v1,
                                                input logic [7:0] v2);
        mtep_rec_t r;
        r.event_kind     = kind;
        r.event_status   = status;
        r.channel        = status[3:0];
        r.delta_ticks    = delta;
        r.first_value    = v1;
        r.second_value   = v2;
        r.meta_byte      = 8'h00;
        r.payload_length = 32'h0;
        r.tempo_us       = 24'h0;
        return r;
    endfunction

    // Meta or sysex record once the payload is consumed.
    function automatic mtep_rec_t mtep_sys_rec(input logic [7:0] status,
                                               input logic [7:0] mtype,
                                               input logic [31:0] len,
                                               input logic [23:0] tempo,
                                               input logic [31:0] delta);
        mtep_rec_t r;
        r = mtep_chan_rec(KIND_SYSEX, status, delta, 8'h00, 8'h00);
        r.payload_length = len;
        if (status == STATUS_META) begin
            r.meta_byte  = mtype;
            r.event_kind = KIND_META;
            if (mtype == META_TEMPO && len == 32'd3) begin
                r.event_kind = KIND_TEMPO;
                r.tempo_us   = tempo;
            end else if (mtype == META_END) begin
                r.event_kind = KIND_END_TRACK;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/midi_track_event_parser_core.sv @@
// A record is registered into the result register (or the skid entry while it is full) and leaves on m_*.
// Throughput: one byte per cycle while s_ready is high; the parse phase and fields update in a single pass.
// A two-entry output buffer (result register plus skid) keeps s_ready up while
// one record waits on m_ready.
// Reset: synchronous, active-low aresetn clears parser state and both buffer entries.
`default_nettype none

module midi_track_event_parser_core
    import mtep_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_track_start,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_event_kind,
    output logic [7:0]       m_event_status,
    output logic [3:0]       m_channel,
    output logic [31:0]      m_delta_time,
    output logic [7:0]       m_first_value,
    output logic [7:0]       m_second_value,
    output logic [7:0]       m_meta_type_out,
    output logic [31:0]      m_payload_length,
    output logic [23:0]      m_tempo_us
);

    logic      take;
    logic      new_valid;
    mtep_rec_t new_rec;
    logic      out_valid_reg;
    mtep_rec_t out_rec_reg;
    logic      skid_valid_reg;
    mtep_rec_t skid_rec_reg;
    logic      push;
    logic      pop;

    // Accept whenever the skid entry is free; the result register may still be full.
    assign s_ready = !skid_valid_reg;
    assign take    = s_valid && s_ready;

    mtep_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .data_byte   (s_data_byte),
        .track_start (s_track_start),
        .rec         (new_rec),
        .rec_valid   (new_valid)
    );

    assign push = take && new_valid;
    assign pop  = out_valid_reg && m_ready;

    // Valid flags: the result register refills from skid first, then from a new item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || pop) begin
                out_valid_reg  <= skid_valid_reg || push;
                skid_valid_reg <= 1'b0;
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_rec_reg <= skid_valid_reg ? skid_rec_reg : new_rec;
        end
        if (push && out_valid_reg && !pop) begin
            skid_rec_reg <= new_rec;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_event_kind     = out_rec_reg.event_kind;
    assign m_event_status   = out_rec_reg.event_status;
    assign m_channel        = out_rec_reg.channel;
    assign m_delta_time     = out_rec_reg.delta_ticks;
    assign m_first_value    = out_rec_reg.first_value;
    assign m_second_value   = out_rec_reg.second_value;
    assign m_meta_type_out  = out_rec_reg.meta_byte;
    assign m_payload_length = out_rec_reg.payload_length;
    assign m_tempo_us       = out_rec_reg.tempo_us;

endmodule

`default_nettype wire

@@ rtl/core/mtep_decode.sv @@
`default_nettype none

module mtep_decode
    import mtep_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       take,
    input  wire logic [7:0] data_byte,
    input  wire logic       track_start,
    output mtep_rec_t       rec,
    output logic            rec_valid
);

    typedef enum logic [2:0] {
        PH_DELTA  = 3'd0,
        PH_STATUS = 3'd1,
        PH_DATA1  = 3'd2,
        PH_DATA2  = 3'd3,
        PH_MTYPE  = 3'd4,
        PH_LEN    = 3'd5,
        PH_SKIP   = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [7:0]  run_reg, run_next, run_cur;
    logic [31:0] delta_reg, delta_next, delta_cur;
    logic [7:0]  cur_reg, cur_next, cur_cur;
    logic [7:0]  first_reg, first_next, first_cur;
    logic [7:0]  mtype_reg, mtype_next, mtype_cur;
    logic [31:0] len_reg, len_next, len_cur;
    logic [31:0] left_reg, left_next, left_cur;
    logic [23:0] tempo_reg, tempo_next, tempo_cur;
    logic [7:0]  eff_status;
    logic [31:0] len_shift;
    logic [31:0] left_dec;
    logic [23:0] tempo_shift;

    always_comb begin
        // Track start wipes the state before this byte is parsed.
        phase_cur = track_start ? PH_DELTA : phase_reg;
        run_cur   = track_start ? 8'h00 : run_reg;
        delta_cur = track_start ? 32'h0 : delta_reg;
        cur_cur   = track_start ? 8'h00 : cur_reg;
        first_cur = track_start ? 8'h00 : first_reg;
        mtype_cur = track_start ? 8'h00 : mtype_reg;
        len_cur   = track_start ? 32'h0 : len_reg;
        left_cur  = track_start ? 32'h0 : left_reg;
        tempo_cur = track_start ? 24'h0 : tempo_reg;

        phase_next = phase_cur;
        run_next   = run_cur;
        delta_next = delta_cur;
        cur_next   = cur_cur;
        first_next = first_cur;
        mtype_next = mtype_cur;
        len_next   = len_cur;
        left_next  = left_cur;
        tempo_next = tempo_cur;
        rec_valid  = 1'b0;
        rec        = mtep_chan_rec(KIND_UNKNOWN, 8'h00, delta_cur, 8'h00, 8'h00);

        eff_status  = (data_byte[7] == 1'b0) ? run_cur : cur_cur;
        len_shift   = {len_cur[24:0], data_byte[6:0]};
        left_dec    = left_cur - 32'd1;
        tempo_shift = {tempo_cur[15:0], data_byte};

        case (phase_cur)
            PH_DELTA: begin
                delta_next = {delta_cur[24:0], data_byte[6:0]};
                if (!data_byte[7]) begin
                    phase_next = PH_STATUS;
                end
            end
            PH_STATUS, PH_DATA1: begin
                if (phase_cur == PH_STATUS && data_byte[7]) begin
                    cur_next = data_byte;
                    if (data_byte < STATUS_SYSTEM) begin
                        run_next   = data_byte;
                        phase_next = PH_DATA1;
                    end else begin
                        run_next   = 8'h00;
                        len_next   = 32'h0;
                        tempo_next = 24'h0;
                        mtype_next = 8'h00;
                        phase_next = (data_byte == STATUS_META) ? PH_MTYPE : PH_LEN;
                    end
                end else if (phase_cur == PH_STATUS && run_cur == 8'h00) begin
                    // Orphan data byte: report unknown, reuse it as the next delta.
                    rec_valid  = 1'b1;
                    delta_next = {24'h0, data_byte};
                end else begin
                    if (phase_cur == PH_STATUS) begin
                        cur_next = run_cur;
                    end else begin
                        eff_status = cur_cur;
                    end
                    if (eff_status[7:4] == CLS_PROGRAM) begin
                        rec_valid  = 1'b1;
                        rec        = mtep_chan_rec(KIND_PROGRAM, eff_status, delta_cur,
                                                   data_byte, 8'h00);
                        phase_next = PH_DELTA;
                        delta_next = 32'h0;
                    end else if (eff_status[7:4] == CLS_PRESSURE) begin
                        rec_valid  = 1'b1;
                        rec        = mtep_chan_rec(KIND_UNKNOWN, eff_status, delta_cur,
                                                   8'h00, 8'h00);
                        phase_next = PH_DELTA;
                        delta_next = 32'h0;
                    end else begin
                        first_next = data_byte;
                        phase_next = PH_DATA2;
                    end
                end
            end
            PH_DATA2: begin
                rec_valid  = 1'b1;
                phase_next = PH_DELTA;
                delta_next = 32'h0;
                case (cur_cur[7:4])
                    CLS_NOTE_OFF: rec = mtep_chan_rec(KIND_NOTE_OFF, cur_cur, delta_cur,
                                                      first_cur, data_byte);
                    CLS_NOTE_ON:  rec = mtep_chan_rec((data_byte == 8'h00) ? KIND_NOTE_OFF
                                                      : KIND_NOTE_ON, cur_cur, delta_cur,
                                                      first_cur, data_byte);
                    CLS_CTRL:     rec = mtep_chan_rec(KIND_CTRL, cur_cur, delta_cur,
                                                      first_cur, data_byte);
                    default:      rec = mtep_chan_rec(KIND_UNKNOWN, cur_cur, delta_cur,
                                                      8'h00, 8'h00);
                endcase
            end
            PH_MTYPE: begin
                mtype_next = data_byte;
                len_next   = 32'h0;
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                len_next = len_shift;
                if (!data_byte[7]) begin
                    left_next  = len_shift;
                    tempo_next = 24'h0;
                    if (len_shift == 32'h0) begin
                        rec_valid  = 1'b1;
                        rec        = mtep_sys_rec(cur_cur, mtype_cur, len_shift, 24'h0,
                                                  delta_cur);
                        phase_next = PH_DELTA;
                        delta_next = 32'h0;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                tempo_next = tempo_shift;
                left_next  = left_dec;
                if (left_dec == 32'h0) begin
                    rec_valid  = 1'b1;
                    rec        = mtep_sys_rec(cur_cur, mtype_cur, len_cur, tempo_shift,
                                              delta_cur);
                    phase_next = PH_DELTA;
                    delta_next = 32'h0;
                end
            end
            default: begin
                phase_next = PH_DELTA;
                delta_next = 32'h0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DELTA;
            run_reg   <= 8'h00;
            delta_reg <= 32'h0;
            cur_reg   <= 8'h00;
            first_reg <= 8'h00;
            mtype_reg <= 8'h00;
            len_reg   <= 32'h0;
            left_reg  <= 32'h0;
            tempo_reg <= 24'h0;
        end else if (take) begin
            phase_reg <= phase_next;
            run_reg   <= run_next;
            delta_reg <= delta_next;
            cur_reg   <= cur_next;
            first_reg <= first_next;
            mtype_reg <= mtype_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            tempo_reg <= tempo_next;
        end
    end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mtep_pkg::*;

    // Run control
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_BYTES  = 1500;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 20;

    // Channel classes the package leaves out; the block reports both as unknown
    localparam logic [3:0] CLS_POLY_PRESSURE = 4'hA;
    localparam logic [3:0] CLS_PITCH_BEND    = 4'hE;

    // Where the parser stands inside the current event
    typedef enum logic [2:0] {
        WAIT_DELTA,
        WAIT_STATUS,
        WAIT_DATA1,
        WAIT_DATA2,
        WAIT_MTYPE,
        WAIT_LEN,
        SKIP_BODY
    } phase_t;

    // One track byte as the driver offers it, with markers for pacing
    typedef struct {
        logic [7:0] data;
        logic       start;
        bit         wait_idle;   // hold this item until no record is outstanding
        bit         rx_hold;     // ask the receiver for a long hold-off
    } track_byte_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte   = 8'h00;
    logic        s_track_start = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [3:0]  m_event_kind;
    logic [7:0]  m_event_status;
    logic [3:0]  m_channel;
    logic [31:0] m_delta_time;
    logic [7:0]  m_first_value;
    logic [7:0]  m_second_value;
    logic [7:0]  m_meta_type_out;
    logic [31:0] m_payload_length;
    logic [23:0] m_tempo_us;

    midi_track_event_parser_core i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_track_start    (s_track_start),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_event_status   (m_event_status),
        .m_channel        (m_channel),
        .m_delta_time     (m_delta_time),
        .m_first_value    (m_first_value),
        .m_second_value   (m_second_value),
        .m_meta_type_out  (m_meta_type_out),
        .m_payload_length (m_payload_length),
        .m_tempo_us       (m_tempo_us)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Event predictor: a private copy of the parser state
    // ------------------------------------------------------------------
    phase_t      phase;
    logic [7:0]  run_status;
    logic [7:0]  cur_status;
    logic [7:0]  held_data1;
    logic [7:0]  held_mtype;
    logic [31:0] delta_sum;
    logic [31:0] length_sum;
    logic [31:0] body_left;
    logic [23:0] tempo_sum;

    mtep_rec_t   due_records[$];   // records predicted but not yet seen on m_*
    track_byte_t byte_queue[$];    // track bytes waiting for the driver

    int fails = 0;
    int cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    int tx_calm = 0;
    int rx_calm = 0;
    int hold_requests = 0;
    int hold_served = 0;

    // Stimulus builder state
    bit         need_start = 1'b0;
    bit         skip_delta = 1'b0;
    bit         mark_idle = 1'b0;
    bit         mark_hold = 1'b0;
    bit         hold_placed = 1'b0;
    bit         idle_placed = 1'b0;
    logic [7:0] gen_run = 8'h00;
    int         directed_count;

    function automatic void clear_parser();
        phase      = WAIT_DELTA;
        run_status = 8'h00;
        cur_status = 8'h00;
        held_data1 = 8'h00;
        held_mtype = 8'h00;
        delta_sum  = 32'h0;
        length_sum = 32'h0;
        body_left  = 32'h0;
        tempo_sum  = 24'h0;
    endfunction

    // Queue one record and start over on the delta of the next event.
    function automatic void push_record(input logic [3:0] kind, input logic [7:0] status,
                                        input logic [7:0] v1, v2, mt,
                                        input logic [31:0] len, input logic [23:0] tempo);
        mtep_rec_t r;
        r.event_kind     = kind;
        r.event_status   = status;
        r.channel        = status[3:0];
        r.delta_ticks    = delta_sum;
        r.first_value    = v1;
        r.second_value   = v2;
        r.meta_byte      = mt;
        r.payload_length = len;
        r.tempo_us       = tempo;
        due_records.push_back(r);
        phase     = WAIT_DELTA;
        delta_sum = 32'h0;
    endfunction

    // Meta or sysex record once the whole body has gone by
    function automatic void close_system();
        if (cur_status == STATUS_META) begin
            if (held_mtype == META_TEMPO && length_sum == 32'd3)
                push_record(KIND_TEMPO, cur_status, 8'h00, 8'h00, held_mtype, length_sum,
                            tempo_sum);
            else if (held_mtype == META_END)
                push_record(KIND_END_TRACK, cur_status, 8'h00, 8'h00, held_mtype, length_sum,
                            24'h0);
            else
                push_record(KIND_META, cur_status, 8'h00, 8'h00, held_mtype, length_sum,
                            24'h0);
        end else begin
            push_record(KIND_SYSEX, cur_status, 8'h00, 8'h00, 8'h00, length_sum, 24'h0);
        end
    endfunction

    // First data byte; program and channel pressure end here
    function automatic void take_first(input logic [7:0] b);
        case (cur_status[7:4])
            CLS_PROGRAM: push_record(KIND_PROGRAM, cur_status, b, 8'h00, 8'h00, 32'h0, 24'h0);
            CLS_PRESSURE: push_record(KIND_UNKNOWN, cur_status, 8'h00, 8'h00, 8'h00, 32'h0,
                                      24'h0);
            default: begin
                held_data1 = b;
                phase      = WAIT_DATA2;
            end
        endcase
    endfunction

    // Advance the predictor by one accepted track byte.
    function automatic void parse_byte(input logic [7:0] b, input logic start);
        logic [3:0] kind;
        logic [7:0] v1, v2;
        // a track start drops whatever event was under way
        if (start)
            clear_parser();
        case (phase)
            WAIT_DELTA: begin
                delta_sum = {delta_sum[24:0], b[6:0]};
                if (!b[7])
                    phase = WAIT_STATUS;
            end
            WAIT_STATUS: begin
                if (!b[7]) begin
                    if (run_status == 8'h00) begin
                        // orphan data byte: report it, then reuse it as the next delta
                        push_record(KIND_UNKNOWN, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 24'h0);
                        delta_sum = {24'h0, b};
                        phase     = WAIT_STATUS;
                    end else begin
                        cur_status = run_status;
                        take_first(b);
                    end
                end else begin
                    cur_status = b;
                    if (b < STATUS_SYSTEM) begin
                        run_status = b;
                        phase      = WAIT_DATA1;
                    end else begin
                        // any system status cancels running status
                        run_status = 8'h00;
                        length_sum = 32'h0;
                        tempo_sum  = 24'h0;
                        held_mtype = 8'h00;
                        phase      = (b == STATUS_META) ? WAIT_MTYPE : WAIT_LEN;
                    end
                end
            end
            WAIT_DATA1: take_first(b);
            WAIT_DATA2: begin
                v1 = held_data1;
                v2 = b;
                case (cur_status[7:4])
                    CLS_NOTE_OFF: kind = KIND_NOTE_OFF;
                    CLS_NOTE_ON:  kind = (b == 8'h00) ? KIND_NOTE_OFF : KIND_NOTE_ON;
                    CLS_CTRL:     kind = KIND_CTRL;
                    default: begin
                        kind = KIND_UNKNOWN;
                        v1   = 8'h00;
                        v2   = 8'h00;
                    end
                endcase
                push_record(kind, cur_status, v1, v2, 8'h00, 32'h0, 24'h0);
            end
            WAIT_MTYPE: begin
                held_mtype = b;
                length_sum = 32'h0;
                phase      = WAIT_LEN;
            end
            WAIT_LEN: begin
                length_sum = {length_sum[24:0], b[6:0]};
                if (!b[7]) begin
                    body_left = length_sum;
                    tempo_sum = 24'h0;
                    if (body_left == 32'h0)
                        close_system();
                    else
                        phase = SKIP_BODY;
                end
            end
            SKIP_BODY: begin
                tempo_sum = {tempo_sum[15:0], b};
                body_left = body_left - 32'd1;
                if (body_left == 32'h0)
                    close_system();
            end
            default: begin
                phase     = WAIT_DELTA;
                delta_sum = 32'h0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builder
    // ------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b);
        track_byte_t it;
        it.data      = b;
        it.start     = need_start;
        it.wait_idle = mark_idle;
        it.rx_hold   = mark_hold;
        need_start   = 1'b0;
        mark_idle    = 1'b0;
        mark_hold    = 1'b0;
        byte_queue.push_back(it);
    endtask

    function automatic logic [7:0] data_value();
        // mostly clean 7-bit data, now and then a byte with the top bit set
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic int body_size();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(0, 8);
    endfunction

    // Variable-length delta, one to six bytes; long ones wrap the 32-bit sum
    task automatic put_delta();
        int n, r;
        logic [6:0] part;
        bit full;
        r    = $urandom_range(0, 99);
        n    = (r < 70) ? 1 : (r < 90) ? 2 : (r < 96) ? $urandom_range(3, 4)
                                                      : $urandom_range(5, 6);
        full = ($urandom_range(0, 19) == 0);
        for (int i = 0; i < n; i++) begin
            part = full ? 7'h7F : 7'($urandom_range(0, 127));
            put_byte({(i < n - 1), part});
        end
    endtask

    // Length field followed by the body bytes it announces
    task automatic put_sized_body(input int len);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 85) begin
            // six-byte form: the leading bits fall off the top of the 32-bit sum
            put_byte(8'h80 | 8'($urandom_range(0, 127)));
            put_byte(8'h80 | (8'($urandom) & 8'h70));
            repeat (3) put_byte(8'h80);
        end else if (r >= 70) begin
            // padded with zero continuation bytes
            repeat ($urandom_range(1, 3)) put_byte(8'h80);
        end
        put_byte(8'(len));
        repeat (len) put_byte(8'($urandom));
    endtask

    // One event, mostly well formed; a share of orphan bytes and noise
    task automatic put_event();
        int r, n;
        logic [3:0] cls;
        logic [7:0] st, mt;
        if (!skip_delta) begin
            if ($urandom_range(0, 49) == 0) begin
                need_start = 1'b1;
                gen_run    = 8'h00;
            end
            put_delta();
        end
        skip_delta = 1'b0;
        r = $urandom_range(0, 99);
        if (r >= 92) begin
            // noise or a cut-off event; resync on a track start
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
            need_start = 1'b1;
            gen_run    = 8'h00;
        end else if (r >= 70 && r < 78 && gen_run == 8'h00) begin
            // data byte with no status in effect; it stands in as the next delta
            put_byte(8'($urandom_range(0, 127)));
            skip_delta = 1'b1;
        end else if (r >= 62 && r < 70) begin
            st = ($urandom_range(0, 2) == 0)
                 ? 8'($urandom_range(STATUS_SYSTEM + 1, STATUS_META - 1)) : STATUS_SYSTEM;
            put_byte(st);
            gen_run = 8'h00;
            put_sized_body(body_size());
        end else if (r >= 48 && r < 62) begin
            put_byte(STATUS_META);
            gen_run = 8'h00;
            r = $urandom_range(0, 99);
            if (r < 45) begin
                mt = META_TEMPO;
                n  = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 6) : 3;
            end else if (r < 60) begin
                mt = META_END;
                n  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
            end else begin
                mt = 8'($urandom);
                n  = body_size();
            end
            put_byte(mt);
            put_sized_body(n);
        end else begin
            if (gen_run != 8'h00 && $urandom_range(0, 2) == 0) begin
                // running status: first data byte sits where a status would
                st = gen_run;
                put_byte(8'($urandom_range(0, 127)));
            end else begin
                case ($urandom_range(0, 9))
                    0:       cls = CLS_NOTE_OFF;
                    1, 2, 3: cls = CLS_NOTE_ON;
                    4, 5:    cls = CLS_CTRL;
                    6:       cls = CLS_PROGRAM;
                    7:       cls = CLS_PRESSURE;
                    8:       cls = CLS_POLY_PRESSURE;
                    default: cls = CLS_PITCH_BEND;
                endcase
                st      = {cls, 4'($urandom)};
                gen_run = st;
                put_byte(st);
                put_byte(data_value());
            end
            if (st[7:4] != CLS_PROGRAM && st[7:4] != CLS_PRESSURE)
                put_byte((st[7:4] == CLS_NOTE_ON && $urandom_range(0, 4) == 0)
                         ? 8'h00 : data_value());
        end
    endtask

    // Idle length shared by both sides: mostly none, some short, a few long,
    // and now and then a calm stretch with no idling at all.
    function automatic int idle_length(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 8)
            calm = $urandom_range(50, 150);
        if (r < 550)
            return 0;
        if (r < 850)
            return $urandom_range(1, 3);
        if (r < 980)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued bytes, predict on every accepted item
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid       <= 1'b0;
            s_data_byte   <= 8'h00;
            s_track_start <= 1'b0;
            gap_left      = 0;
            clear_parser();
        end else begin
            if (s_valid && s_ready)
                parse_byte(s_data_byte, s_track_start);
            // hold the current item until it is taken
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (byte_queue.size() != 0 &&
                             !(byte_queue[0].wait_idle && due_records.size() != 0)) begin
                    if (byte_queue[0].rx_hold)
                        hold_requests++;
                    s_valid       <= 1'b1;
                    s_data_byte   <= byte_queue[0].data;
                    s_track_start <= byte_queue[0].start;
                    void'(byte_queue.pop_front());
                    gap_left = idle_length(tx_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each record against the oldest prediction, pace m_ready
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin
        mtep_rec_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_records.size() == 0) begin
                    $error("event_kind: expected no record, got %0h", m_event_kind);
                    fails++;
                end else begin
                    want = due_records.pop_front();
                    check_field("event_kind", 32'(want.event_kind), 32'(m_event_kind));
                    check_field("event_status", 32'(want.event_status),
                                32'(m_event_status));
                    check_field("channel", 32'(want.channel), 32'(m_channel));
                    check_field("delta_ticks", want.delta_ticks, m_delta_time);
                    check_field("first_value", 32'(want.first_value), 32'(m_first_value));
                    check_field("second_value", 32'(want.second_value),
                                32'(m_second_value));
                    check_field("meta_type_out", 32'(want.meta_byte), 32'(m_meta_type_out));
                    check_field("payload_length", want.payload_length, m_payload_length);
                    check_field("tempo_us", 32'(want.tempo_us), 32'(m_tempo_us));
                end
            end
            // long hold-off on request so the block backs up into s_ready
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                stall_left  = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready    <= 1'b1;
                stall_left = idle_length(rx_calm);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        // Note on, then running status note on with velocity zero as note off
        need_start = 1'b1;
        put_byte(8'h00);
        put_byte({CLS_NOTE_ON, 4'h0});
        put_byte(8'h3C);
        put_byte(8'h40);
        put_byte(8'h00);
        put_byte(8'h3C);
        put_byte(8'h00);
        // Tempo meta; it also cancels running status
        put_byte(8'h00);
        put_byte(STATUS_META);
        put_byte(META_TEMPO);
        put_byte(8'h03);
        put_byte(8'h07);
        put_byte(8'hA1);
        put_byte(8'h20);
        // Orphan data byte, reused as the delta of an explicit note off
        put_byte(8'h10);
        put_byte(8'h40);
        put_byte({CLS_NOTE_OFF, 4'hF});
        put_byte(8'h7F);
        put_byte(8'h00);
        // Program change with a data byte that has the top bit set
        put_byte(8'h00);
        put_byte({CLS_PROGRAM, 4'h5});
        put_byte(8'hFF);
        // Pitch bend cut off by a track start, then a control change
        put_byte(8'h00);
        put_byte({CLS_PITCH_BEND, 4'h9});
        need_start = 1'b1;
        put_byte(8'h00);
        put_byte({CLS_CTRL, 4'h2});
        put_byte(8'h07);
        put_byte(8'h64);
        gen_run        = {CLS_CTRL, 4'h2};
        directed_count = byte_queue.size();

        // Random part: drain after the directed items, one long receiver
        // hold-off, one more drain further on
        mark_idle = 1'b1;
        while (byte_queue.size() < directed_count + RANDOM_BYTES) begin
            if (!hold_placed && byte_queue.size() > directed_count + 500) begin
                mark_hold   = 1'b1;
                hold_placed = 1'b1;
            end
            if (!idle_placed && byte_queue.size() > directed_count + 1000) begin
                mark_idle   = 1'b1;
                idle_placed = 1'b1;
            end
            put_event();
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every byte to be taken and every record to come back
        while (byte_queue.size() != 0 || s_valid || due_records.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
